@@ rtl/core/rwla_pkg.sv @@
// ----------------------------------------------------------------------------
// rwla_pkg
// Shared constants, codes and types for the readers-writer lock arbiter.
// ----------------------------------------------------------------------------
package rwla_pkg;

  localparam int MAX_REQUESTERS   = 64;
  localparam int WAIT_QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS      = 16;

  localparam int ID_W     = 6;
  localparam int KIND_W   = 3;
  localparam int WQ_PTR_W = $clog2(WAIT_QUEUE_DEPTH);
  localparam int WQ_CNT_W = $clog2(WAIT_QUEUE_DEPTH + 1);
  localparam int HOLD_W   = $clog2(MAX_REQUESTERS + 1);
  localparam int RES_W    = $clog2(MAX_RESULTS + 1);

  // result kinds
  localparam logic [KIND_W-1:0] EV_GRANTED   = 3'd0;
  localparam logic [KIND_W-1:0] EV_QUEUED    = 3'd1;
  localparam logic [KIND_W-1:0] EV_HELD      = 3'd2;
  localparam logic [KIND_W-1:0] EV_FREE      = 3'd3;
  localparam logic [KIND_W-1:0] EV_REJECTED  = 3'd4;
  localparam logic [KIND_W-1:0] EV_NO_HOLDER = 3'd5;

  // lock status
  localparam logic [1:0] LK_FREE    = 2'd0;
  localparam logic [1:0] LK_READERS = 2'd1;
  localparam logic [1:0] LK_WRITER  = 2'd2;

  // input action
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] id;
  } wq_ctl_t;

  typedef struct packed {
    logic [WQ_CNT_W-1:0] count;
    logic                full;
    logic [ID_W-1:0]     head_id;
  } wq_stat_t;

endpackage

@@ rtl/core/reader_writer_lock_arbiter.sv @@
// ----------------------------------------------------------------------------
// reader_writer_lock_arbiter
// Readers-writer lock manager with reader preference and wait FIFOs.
// ----------------------------------------------------------------------------
// Results: a request or simple release yields a single registered result; a
//   release that wakes waiters yields one result per grant instead, each after
//   a wait FIFO RAM read, then output load. Input stalls while waking or held.
// Reset: rst synchronous, active high; lock free, holder count and FIFO
//   pointers cleared. FIFO RAM contents are not cleared (only written slots
//   are ever used).
// ----------------------------------------------------------------------------
module reader_writer_lock_arbiter (
  input  logic       clk,
  input  logic       rst,
  // request/release stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [5:0] requester_id, [7:6] zero
  input  logic [1:0] s_tuser,   // [0] action, [1] is_reader
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [5:0] subject_id, [7:6] zero
  output logic [2:0] m_tuser,   // [2:0] event_kind
  output logic       m_tlast
);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_ISSUE = 3'd1;
  localparam logic [2:0] S_RD_EMIT  = 3'd2;
  localparam logic [2:0] S_WR_ISSUE = 3'd3;
  localparam logic [2:0] S_WR_EMIT  = 3'd4;

  localparam logic [rwla_pkg::HOLD_W-1:0] HOLD_MAX =
    rwla_pkg::HOLD_W'(rwla_pkg::MAX_REQUESTERS);
  localparam logic [rwla_pkg::RES_W-1:0] RES_MAX =
    rwla_pkg::RES_W'(rwla_pkg::MAX_RESULTS);

  logic [2:0]                  state, state_next;
  logic [1:0]                  lock_status, lock_status_next;
  logic [rwla_pkg::HOLD_W-1:0] holder_count, holder_count_next;
  logic [rwla_pkg::RES_W-1:0]  wake_count, wake_count_next;

  // output register
  logic                        out_load;
  logic [rwla_pkg::KIND_W-1:0] out_kind, kind_reg;
  logic [rwla_pkg::ID_W-1:0]   out_id, id_reg;
  logic                        out_last, last_reg;
  logic                        out_free;

  rwla_pkg::wq_ctl_t  rq_ctl, wq_ctl;
  rwla_pkg::wq_stat_t rq_stat, wq_stat;

  logic                      accept;
  logic                      act;
  logic                      is_reader;
  logic [rwla_pkg::ID_W-1:0] req_id;
  logic                      lock_free;
  logic [rwla_pkg::HOLD_W-1:0] holder_dec;
  logic                      q_full;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign act       = s_tuser[0];
  assign is_reader = s_tuser[1];
  assign req_id    = s_tdata[rwla_pkg::ID_W-1:0];

  // lock counts as free when nobody holds it
  assign lock_free  = (lock_status == rwla_pkg::LK_FREE) || (holder_count == '0);
  assign holder_dec = holder_count - 1'b1;
  assign q_full     = is_reader ? rq_stat.full : wq_stat.full;

  rwla_wait_queue u_rd_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rq_ctl),
    .stat (rq_stat)
  );

  rwla_wait_queue u_wr_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (wq_ctl),
    .stat (wq_stat)
  );

  always_comb begin
    state_next        = state;
    lock_status_next  = lock_status;
    holder_count_next = holder_count;
    wake_count_next   = wake_count;
    out_load          = 1'b0;
    out_kind          = rwla_pkg::EV_GRANTED;
    out_id            = '0;
    out_last          = 1'b1;
    rq_ctl            = '0;
    wq_ctl            = '0;
    rq_ctl.id         = req_id;
    wq_ctl.id         = req_id;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (act == rwla_pkg::ACT_REQUEST) begin
            out_load = 1'b1;
            out_id   = req_id;
            if (lock_free) begin
              lock_status_next  = is_reader ? rwla_pkg::LK_READERS : rwla_pkg::LK_WRITER;
              holder_count_next = rwla_pkg::HOLD_W'(1);
              out_kind          = rwla_pkg::EV_GRANTED;
            end else if (is_reader && lock_status == rwla_pkg::LK_READERS) begin
              // reader preference: join even with writers waiting
              if (holder_count < HOLD_MAX) begin
                holder_count_next = holder_count + 1'b1;
                out_kind          = rwla_pkg::EV_GRANTED;
              end else begin
                out_kind = rwla_pkg::EV_REJECTED;
              end
            end else if (q_full) begin
              out_kind = rwla_pkg::EV_REJECTED;
            end else begin
              out_kind    = rwla_pkg::EV_QUEUED;
              rq_ctl.push = is_reader;
              wq_ctl.push = !is_reader;
            end
          end else begin
            if (lock_free) begin
              out_load = 1'b1;
              out_kind = rwla_pkg::EV_NO_HOLDER;
            end else if (holder_dec != '0) begin
              out_load          = 1'b1;
              out_kind          = rwla_pkg::EV_HELD;
              holder_count_next = holder_dec;
            end else if (rq_stat.count != '0) begin
              // last holder out: wake readers one per grant
              lock_status_next  = rwla_pkg::LK_READERS;
              holder_count_next = '0;
              wake_count_next   = '0;
              state_next        = S_RD_ISSUE;
            end else if (wq_stat.count != '0) begin
              holder_count_next = '0;
              state_next        = S_WR_ISSUE;
            end else begin
              out_load          = 1'b1;
              out_kind          = rwla_pkg::EV_FREE;
              lock_status_next  = rwla_pkg::LK_FREE;
              holder_count_next = '0;
            end
          end
        end
      end

      // head slot read is in flight
      S_RD_ISSUE: state_next = S_RD_EMIT;
      S_WR_ISSUE: state_next = S_WR_EMIT;

      S_RD_EMIT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_kind          = rwla_pkg::EV_GRANTED;
          out_id            = rq_stat.head_id;
          rq_ctl.pop        = 1'b1;
          holder_count_next = holder_count + 1'b1;
          wake_count_next   = wake_count + 1'b1;
          out_last = (rq_stat.count == rwla_pkg::WQ_CNT_W'(1)) ||
                     (wake_count + 1'b1 == RES_MAX) ||
                     (holder_count + 1'b1 == HOLD_MAX);
          state_next = out_last ? S_IDLE : S_RD_ISSUE;
        end
      end

      S_WR_EMIT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_kind          = rwla_pkg::EV_GRANTED;
          out_id            = wq_stat.head_id;
          wq_ctl.pop        = 1'b1;
          lock_status_next  = rwla_pkg::LK_WRITER;
          holder_count_next = rwla_pkg::HOLD_W'(1);
          state_next        = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lock_status  <= rwla_pkg::LK_FREE;
      holder_count <= '0;
      wake_count   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      lock_status  <= lock_status_next;
      holder_count <= holder_count_next;
      wake_count   <= wake_count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_reg <= out_kind;
      id_reg   <= out_id;
      last_reg <= out_last;
    end
  end

  assign m_tdata = {{(8 - rwla_pkg::ID_W){1'b0}}, id_reg};
  assign m_tuser = kind_reg;
  assign m_tlast = last_reg;

  // holder count stays within the requester limit
  assert property (@(posedge clk) disable iff (rst) holder_count <= HOLD_MAX)
    else $error("holder count above limit");

  // an idle free lock has no holders
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && lock_status == rwla_pkg::LK_FREE) |-> holder_count == '0)
    else $error("free lock with holders");

  // a writer lock is held by exactly one when idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && lock_status == rwla_pkg::LK_WRITER) |-> holder_count == 1)
    else $error("writer lock holder count wrong");

  // wake-up pops only from a non-empty queue
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_EMIT) |-> rq_stat.count != '0)
    else $error("reader wake from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_EMIT) |-> wq_stat.count != '0)
    else $error("writer wake from empty queue");

endmodule

@@ rtl/core/rwla_ram.sv @@
// ----------------------------------------------------------------------------
// rwla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rwla_wait_queue.sv @@
// ----------------------------------------------------------------------------
// rwla_wait_queue
// Wait FIFO of requester ids: pointers and count in flops, slots in a RAM.
// ----------------------------------------------------------------------------
module rwla_wait_queue (
  input  logic              clk,
  input  logic              rst,
  input  rwla_pkg::wq_ctl_t ctl,
  output rwla_pkg::wq_stat_t stat
);

  logic [rwla_pkg::WQ_PTR_W-1:0] head;
  logic [rwla_pkg::WQ_PTR_W-1:0] tail;
  logic [rwla_pkg::WQ_CNT_W-1:0] count;
  logic [rwla_pkg::WQ_PTR_W-1:0] head_next;
  logic [rwla_pkg::WQ_PTR_W-1:0] tail_next;
  logic [rwla_pkg::ID_W-1:0]     rdata;

  localparam logic [rwla_pkg::WQ_PTR_W-1:0] LAST_SLOT =
    rwla_pkg::WQ_PTR_W'(rwla_pkg::WAIT_QUEUE_DEPTH - 1);

  assign head_next = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_next = (tail == LAST_SLOT) ? '0 : tail + 1'b1;

  // read port always follows head; data is registered, valid the cycle after head settles
  rwla_ram #(
    .WIDTH (rwla_pkg::ID_W),
    .DEPTH (rwla_pkg::WAIT_QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (tail),
    .wdata (ctl.id),
    .raddr (head),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        tail <= tail_next;
      end
      if (ctl.pop) begin
        head <= head_next;
      end
      case ({ctl.push, ctl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign stat.count   = count;
  assign stat.full    = (count == rwla_pkg::WQ_CNT_W'(rwla_pkg::WAIT_QUEUE_DEPTH));
  assign stat.head_id = rdata;

endmodule
